[rtl/timed_linear_ramp_interpolator_assert.svh]
// Assertion macros shared by the RTL
`ifndef TIMED_LINEAR_RAMP_INTERPOLATOR_ASSERT_SVH
`define TIMED_LINEAR_RAMP_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define TLRI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlri assertion failed");

// next-cycle implication
`define TLRI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlri assertion failed");

`endif

[rtl/tlri_pkg.sv]
package tlri_pkg;

   // field widths
   localparam int TIME_W      = 32;
   localparam int VAL_W       = 32;
   localparam int DT_W        = 37;
   localparam int RSP_DATA_W  = 136;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // frame dt scaling: 0.1 in single precision is TENTH_MANT / 2^TENTH_SHIFT
   localparam int              DT_FRACTION_BITS = 8;
   localparam int              TENTH_SHIFT      = 27;
   localparam int              DT_SHIFT         = TENTH_SHIFT - DT_FRACTION_BITS;
   localparam logic [23:0]     TENTH_MANT       = 24'd13421773;

   // shared multiplier: signed 33 x 33
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 65;

   // shared divider: 64 / 32, two quotient bits per cycle
   localparam int DIV_W       = 64;
   localparam int DIVISOR_W   = 32;
   localparam int DIV_CYCLES  = DIV_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_WINDOW = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_FROM   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_TO     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_WINDOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_START    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_TARGET   = 3'd5;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/tlri_mul.sv]
module tlri_mul import tlri_pkg::*; (
   input  logic                    clock,
   input  logic signed [MUL_W-1:0] mul_a,
   input  logic signed [MUL_W-1:0] mul_b,
   output logic [PROD_W-1:0]       prod
);

   logic signed [PROD_W-1:0] prod_ff;

   // one signed product per cycle, registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

[rtl/tlri_div.sv]
module tlri_div import tlri_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef struct packed {
      logic [DIVISOR_W-1:0] rem;
      logic [DIV_W-1:0]     quo;
   } div_state_type;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   div_state_type        st_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   div_state_type        step1, step2;

   // one restoring step: shift in a dividend bit, subtract if it fits
   function automatic div_state_type div_step(div_state_type s, logic [DIVISOR_W-1:0] d);
      logic [DIVISOR_W:0] shifted;
      logic               ge;
      div_state_type      r;
      shifted = {s.rem, s.quo[DIV_W-1]};
      ge      = shifted >= {1'b0, d};
      r.rem   = ge ? DIVISOR_W'(shifted - {1'b0, d}) : shifted[DIVISOR_W-1:0];
      r.quo   = {s.quo[DIV_W-2:0], ge};
      return r;
   endfunction

   // two quotient bits per cycle
   always_comb begin
      step1 = div_step(st_ff, divisor_ff);
      step2 = div_step(step1, divisor_ff);
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = busy_ff && (cnt_ff == DIV_LAST);
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // partial remainder and dividend/quotient shift register
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         st_ff.rem  <= '0;
         st_ff.quo  <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         st_ff <= step2;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = st_ff.quo;

endmodule

[rtl/timed_linear_ramp_interpolator.sv]
// Channel  Dir  Word payload (low bit up)
// -------  ---  ---------------------------------------------------------
// req      in   now_time[31:0]
// rsp      out  count_value[31:0], dir_x, dir_z, frame_dt[36:0], 3 pad bits
// csr      in   csr_index selects register, csr_data[63:0] is the value
//
// Each word takes four passes of the shared divider from acceptance to
// rsp_tvalid; a new req word is taken only while the sequencer is idle.
// Reset is synchronous, active high; it clears registers and held state, not dt.
// While a finished word waits on rsp, the next req word is taken; the block
// stalls in its last step only if the output word is still not taken then.
// csr writes are always ready and are meant for idle periods only.
`include "timed_linear_ramp_interpolator_assert.svh"

module timed_linear_ramp_interpolator import tlri_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TIME_W-1:0]      req_tdata,   // now_time
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // count_value, dir_x, dir_z, frame_dt
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_M_DT  = 14'b00000000000010,
      ST_M_CA  = 14'b00000000000100,
      ST_M_CB  = 14'b00000000001000,
      ST_D_CA  = 14'b00000000010000,
      ST_W_CA  = 14'b00000000100000,
      ST_D_CB  = 14'b00000001000000,
      ST_W_CB  = 14'b00000010000000,
      ST_M_T   = 14'b00000100000000,
      ST_M_S   = 14'b00001000000000,
      ST_S_SUM = 14'b00010000000000,
      ST_D_D   = 14'b00100000000000,
      ST_W_D   = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      comp_ff, comp_in;         // 0: X component, 1: Z component
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_load;

   // configuration
   logic [CSR_DATA_W-1:0] count_window_ff, dir_window_ff, dir_start_ff, dir_target_ff;
   logic [VAL_W-1:0]      count_from_ff, count_to_ff;

   // held state
   logic [VAL_W-1:0]  held_count_ff, held_dx_ff, held_dz_ff;
   logic [TIME_W-1:0] last_ff;
   logic [DT_W-1:0]   rsp_dt_ff;

   // working registers
   logic [TIME_W-1:0] now_ff;
   logic [DT_W-1:0]   dt_ff;
   logic [VAL_W-1:0]  num_a_ff, num_b_ff, cnt_ff, dx_ff, dz_ff;
   logic [ACC_W-1:0]  acc_ff;

   // shared units
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0]       prod;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic                    div_wait;   // sequencer waits on the divider

   // decoded fields
   logic [TIME_W-1:0] cb, ce, db, de, cspan, dspan, ela, rem, delta;
   logic [VAL_W-1:0]  tx, tz, sx, sz, t_sel, s_sel;
   logic              c_act, c_in, d_act, d_in;
   logic [VAL_W-1:0]  mag_a, mag_b, cspan_mag, dspan_mag;
   logic [DIV_W-1:0]  acc_mag;
   logic [VAL_W-1:0]  q32, cq, dir_q;
   logic              cq_neg, dq_neg;
   logic [DIV_W-1:0]  qd;

   tlri_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   tlri_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // window and operand decode
   always_comb begin
      cb    = count_window_ff[63:32];
      ce    = count_window_ff[31:0];
      db    = dir_window_ff[63:32];
      de    = dir_window_ff[31:0];
      tx    = dir_target_ff[63:32];
      tz    = dir_target_ff[31:0];
      sx    = dir_start_ff[63:32];
      sz    = dir_start_ff[31:0];
      cspan = ce - cb;
      dspan = de - db;
      ela   = now_ff - db;
      rem   = de - now_ff;
      delta = now_ff - last_ff;
      t_sel = comp_ff ? tz : tx;
      s_sel = comp_ff ? sz : sx;
      c_act = cb != ce;
      c_in  = ce > now_ff;
      d_act = db != de;
      d_in  = de > now_ff;
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_M_DT: begin
            mul_a = {1'b0, delta};
            mul_b = MUL_W'(TENTH_MANT);
         end
         ST_M_CA: begin
            mul_a = {count_to_ff[VAL_W-1], count_to_ff};
            mul_b = {cb[TIME_W-1] ^ 1'b0, now_ff - cb};
         end
         ST_M_CB: begin
            mul_a = {1'b0, ce - now_ff};
            mul_b = {count_from_ff[VAL_W-1], count_from_ff};
         end
         ST_M_T: begin
            mul_a = {t_sel[VAL_W-1], t_sel};
            mul_b = {ela[TIME_W-1], ela};
         end
         ST_M_S: begin
            mul_a = {s_sel[VAL_W-1], s_sel};
            mul_b = {rem[TIME_W-1], rem};
         end
         default: ;
      endcase
   end

   // magnitudes for the divider
   always_comb begin
      mag_a     = num_a_ff[VAL_W-1] ? (32'd0 - num_a_ff) : num_a_ff;
      mag_b     = num_b_ff[VAL_W-1] ? (32'd0 - num_b_ff) : num_b_ff;
      cspan_mag = cspan[TIME_W-1] ? (32'd0 - cspan) : cspan;
      dspan_mag = dspan[TIME_W-1] ? (32'd0 - dspan) : dspan;
      acc_mag   = acc_ff[ACC_W-1] ? DIV_W'(65'd0 - acc_ff) : acc_ff[DIV_W-1:0];
   end

   // divider request
   always_comb begin
      div_req.start    = (state_ff == ST_D_CA) || (state_ff == ST_D_CB) ||
                         (state_ff == ST_D_D);
      div_req.dividend = acc_mag;
      if (state_ff == ST_D_CA) begin
         div_req.dividend = {32'd0, mag_a};
      end else if (state_ff == ST_D_CB) begin
         div_req.dividend = {32'd0, mag_b};
      end
      div_req.divisor = (state_ff == ST_D_D) ? dspan_mag : cspan_mag;
   end

   // signed count quotient, truncated toward zero and wrapping
   always_comb begin
      q32    = div_rsp.quotient[VAL_W-1:0];
      cq_neg = ((state_ff == ST_W_CA) ? num_a_ff[VAL_W-1] : num_b_ff[VAL_W-1]) ^
               cspan[TIME_W-1];
      cq     = cq_neg ? (32'd0 - q32) : q32;
   end

   // signed direction quotient, saturated to 32 bits
   always_comb begin
      qd     = div_rsp.quotient;
      dq_neg = acc_ff[ACC_W-1] ^ dspan[TIME_W-1];
      if (dq_neg) begin
         dir_q = (qd > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                 : (32'd0 - qd[VAL_W-1:0]);
      end else begin
         dir_q = (qd > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : qd[VAL_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      comp_in  = comp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_M_DT;
               comp_in  = 1'b0;
            end
         end
         ST_M_DT:  state_in = ST_M_CA;
         ST_M_CA:  state_in = ST_M_CB;
         ST_M_CB:  state_in = ST_D_CA;
         ST_D_CA:  state_in = ST_W_CA;
         ST_W_CA:  if (div_rsp.done) state_in = ST_D_CB;
         ST_D_CB:  state_in = ST_W_CB;
         ST_W_CB:  if (div_rsp.done) state_in = ST_M_T;
         ST_M_T:   state_in = ST_M_S;
         ST_M_S:   state_in = ST_S_SUM;
         ST_S_SUM: state_in = ST_D_D;
         ST_D_D:   state_in = ST_W_D;
         ST_W_D: begin
            if (div_rsp.done) begin
               state_in = comp_ff ? ST_OUT : ST_M_T;
               comp_in  = 1'b1;
            end
         end
         ST_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rsp_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         comp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_window_ff <= '0;
         count_from_ff   <= '0;
         count_to_ff     <= '0;
         dir_window_ff   <= '0;
         dir_start_ff    <= '0;
         dir_target_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COUNT_WINDOW: count_window_ff <= csr_data;
            CSR_COUNT_FROM:   count_from_ff   <= csr_data[VAL_W-1:0];
            CSR_COUNT_TO:     count_to_ff     <= csr_data[VAL_W-1:0];
            CSR_DIR_WINDOW:   dir_window_ff   <= csr_data;
            CSR_DIR_START:    dir_start_ff    <= csr_data;
            CSR_DIR_TARGET:   dir_target_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // working datapath
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ff <= req_tdata;
      end
      case (state_ff)
         ST_M_CA:  dt_ff    <= prod[DT_SHIFT +: DT_W];
         ST_M_CB:  num_a_ff <= prod[VAL_W-1:0];
         ST_D_CA:  num_b_ff <= prod[VAL_W-1:0];
         ST_W_CA:  if (div_rsp.done) cnt_ff <= cq;
         ST_W_CB:  if (div_rsp.done) cnt_ff <= cnt_ff + cq;
         ST_M_S:   acc_ff   <= prod[ACC_W-1:0];
         ST_S_SUM: acc_ff   <= acc_ff + prod[ACC_W-1:0];
         ST_W_D: begin
            if (div_rsp.done) begin
               if (comp_ff) begin
                  dz_ff <= dir_q;
               end else begin
                  dx_ff <= dir_q;
               end
            end
         end
         default: ;
      endcase
   end

   // held values double as the output word
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         held_dx_ff    <= '0;
         held_dz_ff    <= '0;
         last_ff       <= '0;
      end else if (rsp_load) begin
         if (c_act) begin
            held_count_ff <= c_in ? cnt_ff : count_to_ff;
         end
         if (d_act) begin
            held_dx_ff <= d_in ? dx_ff : tx;
            held_dz_ff <= d_in ? dz_ff : tz;
         end
         last_ff <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_dt_ff <= dt_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_dt_ff, held_dz_ff, held_dx_ff, held_count_ff};
   assign csr_ready  = 1'b1;
   assign div_wait   = (state_ff == ST_W_CA) || (state_ff == ST_W_CB) || (state_ff == ST_W_D);

   // checks
   `TLRI_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `TLRI_ASSERT_IMP(a_done_in_wait, clock, reset, div_rsp.done, div_wait)
   `TLRI_ASSERT_NEXT(a_load_shows, clock, reset, rsp_load, rsp_tvalid && req_tready)

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import tlri_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 160;     // idle tail after the last result word is back
   localparam int IDLE_CYCLES     = 8;
   localparam int PHASES          = 30;
   localparam int WORDS_PER_PHASE = 40;
   localparam int GAP_MAX         = 11;

   // 0.1 in single precision is 13421773 / 2^27
   localparam logic [63:0] TENTH_NUM = 64'd13421773;
   localparam int          TENTH_EXP = 27;

   // saturation bounds of a Q16.16 component
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   // unmapped register indexes, writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic [VAL_W-1:0] count_value;
      logic [VAL_W-1:0] dir_x;
      logic [VAL_W-1:0] dir_z;
      logic [DT_W-1:0]  frame_dt;
   } frame_state_t;

   typedef struct {
      logic [CSR_DATA_W-1:0] count_window;
      logic [CSR_DATA_W-1:0] count_from;
      logic [CSR_DATA_W-1:0] count_to;
      logic [CSR_DATA_W-1:0] dir_window;
      logic [CSR_DATA_W-1:0] dir_start;
      logic [CSR_DATA_W-1:0] dir_target;
   } ramp_regs_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [TIME_W-1:0]      req_tdata;    // now_time
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;    // count_value, dir_x, dir_z, frame_dt, pad
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // register copy and held values as the block should have them
   ramp_regs_t   cfg = '{default: '0};
   logic [31:0]  held_cnt   = '0;
   logic [31:0]  held_x     = '0;
   logic [31:0]  held_z     = '0;
   logic [31:0]  prev_stamp = '0;
   frame_state_t frames_due[$];

   bit send_gaps  = 1'b0;
   bit rsp_stalls = 1'b0;
   int errors          = 0;
   int words_sent      = 0;
   int words_seen      = 0;
   int settings_loaded = 0;
   int cycles          = 0;
   int stall_left      = 0;

   timed_linear_ramp_interpolator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d words pending", $time, cycles,
                  frames_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // signed 32-bit quotient truncated toward zero; min / -1 wraps back to min
   function automatic logic [31:0] quot_wrap(input logic [31:0] num, input logic [31:0] den);
      logic signed [33:0] n;
      logic signed [33:0] d;
      logic signed [33:0] q;
      n = {{2{num[31]}}, num};
      d = {{2{den[31]}}, den};
      q = n / d;
      return q[31:0];
   endfunction

   // (to*elapsed + from*remaining) / span, exact, truncated, saturated to 32 bits
   function automatic logic [31:0] blend_q16(input logic [31:0] to_v, input logic [31:0] from_v,
                                             input logic [31:0] elapsed,
                                             input logic [31:0] remaining,
                                             input logic [31:0] span);
      logic signed [65:0] t;
      logic signed [65:0] f;
      logic signed [65:0] e;
      logic signed [65:0] r;
      logic signed [65:0] s;
      logic signed [65:0] q;
      t = {{34{to_v[31]}}, to_v};
      f = {{34{from_v[31]}}, from_v};
      e = {{34{elapsed[31]}}, elapsed};
      r = {{34{remaining[31]}}, remaining};
      s = {{34{span[31]}}, span};
      q = (t * e + f * r) / s;
      if (q > SAT_HI) return 32'h7FFF_FFFF;
      if (q < SAT_LO) return 32'h8000_0000;
      return q[31:0];
   endfunction

   // advance held count, direction and last time by one frame stamp
   function automatic frame_state_t advance_frame(input logic [31:0] stamp);
      frame_state_t f;
      logic [31:0]  c_beg;
      logic [31:0]  c_end;
      logic [31:0]  d_beg;
      logic [31:0]  d_end;
      logic [31:0]  span;
      logic [31:0]  rem;
      logic [31:0]  part_to;
      logic [31:0]  part_from;
      logic [63:0]  scaled;
      c_beg = cfg.count_window[63:32];
      c_end = cfg.count_window[31:0];
      d_beg = cfg.dir_window[63:32];
      d_end = cfg.dir_window[31:0];

      // count ramp, inactive when the window is empty
      if (c_beg != c_end) begin
         if (stamp < c_end) begin
            span      = c_end - c_beg;
            part_to   = cfg.count_to[31:0] * (stamp - c_beg);
            part_from = (c_end - stamp) * cfg.count_from[31:0];
            held_cnt  = quot_wrap(part_to, span) + quot_wrap(part_from, span);
         end else begin
            held_cnt = cfg.count_to[31:0];
         end
      end

      // direction ramp
      if (d_beg != d_end) begin
         if (stamp < d_end) begin
            span   = d_end - d_beg;
            rem    = d_end - stamp;
            held_x = blend_q16(cfg.dir_target[63:32], cfg.dir_start[63:32], span - rem, rem, span);
            held_z = blend_q16(cfg.dir_target[31:0], cfg.dir_start[31:0], span - rem, rem, span);
         end else begin
            held_x = cfg.dir_target[63:32];
            held_z = cfg.dir_target[31:0];
         end
      end

      // dt = elapsed * 0.1, truncated to Q.F
      scaled     = ({32'd0, stamp - prev_stamp} * TENTH_NUM) >> (TENTH_EXP - DT_FRACTION_BITS);
      prev_stamp = stamp;

      f.count_value = held_cnt;
      f.dir_x       = held_x;
      f.dir_z       = held_z;
      f.frame_dt    = scaled[DT_W-1:0];
      return f;
   endfunction

   // window {start, end}: empty, short, long, reversed, random, or hugging the time range edges
   function automatic logic [63:0] pick_window();
      logic [31:0] beg;
      logic [31:0] len;
      beg = $urandom;
      case ($urandom_range(0, 9))
         0:       len = 32'd0;
         1, 2:    len = $urandom_range(1, 16);
         3, 4, 5: len = $urandom_range(17, 5000);
         6:       len = $urandom_range(5001, 32'h7FFF_FFFF);
         7:       len = 32'd0 - $urandom_range(1, 5000);
         8:       len = $urandom;
         default: begin
            len = $urandom_range(1, 5000);
            beg = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF - len;
         end
      endcase
      return {beg, beg + len};
   endfunction

   // 32-bit level: extremes, small values around zero, or anything
   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
         3, 4:    return $urandom_range(0, 200000) - 32'd100000;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string what, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      end
   endtask

   // result side: random stalls while a word is offered, then check it
   always @(posedge clock) begin
      frame_state_t want;
      int           n;
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (frames_due.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing pending: %h", $time, rsp_tdata);
         end else begin
            want = frames_due.pop_front();
            words_seen++;
            check_field("count_value", 64'(want.count_value), 64'(rsp_tdata[VAL_W-1:0]));
            check_field("dir_x", 64'(want.dir_x), 64'(rsp_tdata[2*VAL_W-1:VAL_W]));
            check_field("dir_z", 64'(want.dir_z), 64'(rsp_tdata[3*VAL_W-1:2*VAL_W]));
            check_field("frame_dt", 64'(want.frame_dt),
                        64'(rsp_tdata[3*VAL_W+DT_W-1:3*VAL_W]));
         end
         n = rsp_stalls ? $urandom_range(0, GAP_MAX) : 0;
         stall_left <= n;
         rsp_tready <= (n == 0);
      end else if (rsp_tvalid && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end
   end

   // stop sending and wait until every word is back, then idle for the given tail
   task automatic drain(input int tail);
      req_tvalid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COUNT_WINDOW: cfg.count_window = value;
         CSR_COUNT_FROM:   cfg.count_from   = value;
         CSR_COUNT_TO:     cfg.count_to     = value;
         CSR_DIR_WINDOW:   cfg.dir_window   = value;
         CSR_DIR_START:    cfg.dir_start    = value;
         CSR_DIR_TARGET:   cfg.dir_target   = value;
         default: ;
      endcase
   endtask

   // load a full register set once the block is idle; one or two unmapped writes ride along
   task automatic program_regs(input ramp_regs_t plan);
      drain(IDLE_CYCLES);
      write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, {$urandom, $urandom});
      write_reg(CSR_COUNT_WINDOW, plan.count_window);
      write_reg(CSR_COUNT_FROM, plan.count_from);
      write_reg(CSR_COUNT_TO, plan.count_to);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_SPARE_HI, {$urandom, $urandom});
      write_reg(CSR_DIR_WINDOW, plan.dir_window);
      write_reg(CSR_DIR_START, plan.dir_start);
      write_reg(CSR_DIR_TARGET, plan.dir_target);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_loaded++;
   endtask

   task automatic send_stamp(input logic [31:0] stamp);
      int gap;
      gap = send_gaps ? $urandom_range(0, GAP_MAX) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
      frames_due.push_back(advance_frame(stamp));
      words_sent++;
   endtask

   // reset registers: windows inactive, only dt moves; time extremes and wrap
   task automatic test_power_up();
      send_stamp(32'd0);
      send_stamp(32'hFFFF_FFFF);
      send_stamp(32'd0);
      send_stamp(32'd1);
   endtask

   // count ramp before, across and after its window
   task automatic test_count_ramp();
      program_regs('{count_window: {32'd1000, 32'd2000},
                     count_from:   64'hDEAD_BEEF_FFFF_FE0C,
                     count_to:     64'd70000,
                     dir_window:   {32'd5, 32'd5},
                     dir_start:    64'h0001_0000_FFFF_0000,
                     dir_target:   64'h0000_8000_0002_0000});
      send_stamp(32'd999);
      send_stamp(32'd1000);
      send_stamp(32'd1500);
      send_stamp(32'd1999);
      send_stamp(32'd2000);
      send_stamp(32'd5000);
   endtask

   // span of -1 with a product of min: quotient wraps to min
   task automatic test_wrap_quotient();
      program_regs('{count_window: {32'h10, 32'h0F},
                     count_from:   64'd0,
                     count_to:     64'h4000_0000,
                     dir_window:   64'd0,
                     dir_start:    64'd0,
                     dir_target:   64'd0});
      send_stamp(32'h0E);
      send_stamp(32'h0F);
      send_stamp(32'h0E);
   endtask

   // reversed windows on both ramps, direction driven into saturation
   task automatic test_reversed_windows();
      program_regs('{count_window: {32'd3000, 32'd1000},
                     count_from:   64'h8000_0000,
                     count_to:     64'h7FFF_FFFF,
                     dir_window:   {32'h8000_0000, 32'h10},
                     dir_start:    {32'h8000_0000, 32'h7FFF_FFFF},
                     dir_target:   {32'h7FFF_FFFF, 32'h8000_0000}});
      send_stamp(32'd0);
      send_stamp(32'd8);
      send_stamp(32'h0F);
      send_stamp(32'h10);
      send_stamp(32'd500);
   endtask

   // windows spanning the whole time range, extreme levels
   task automatic test_full_range();
      program_regs('{count_window: {32'd0, 32'hFFFF_FFFF},
                     count_from:   64'hFFFF_FFFF_7FFF_FFFF,
                     count_to:     64'h0000_0000_8000_0000,
                     dir_window:   {32'd0, 32'hFFFF_FFFF},
                     dir_start:    64'hFFFF_FFFF_FFFF_FFFF,
                     dir_target:   64'h7FFF_FFFF_7FFF_FFFF});
      send_stamp(32'd0);
      send_stamp(32'h7FFF_FFFF);
      send_stamp(32'hFFFF_FFFE);
      send_stamp(32'hFFFF_FFFF);
   endtask

   // random register sets; stamps mostly walk frames or land in and around windows
   task automatic test_random_phases();
      ramp_regs_t  plan;
      logic [31:0] stamp;
      logic [31:0] w_beg;
      logic [31:0] w_end;
      for (int p = 0; p < PHASES; p++) begin
         plan.count_window = pick_window();
         plan.count_from   = {$urandom, pick_level()};
         plan.count_to     = {$urandom, pick_level()};
         plan.dir_window   = pick_window();
         plan.dir_start    = {pick_level(), pick_level()};
         plan.dir_target   = {pick_level(), pick_level()};
         program_regs(plan);
         send_gaps  = ($urandom_range(0, 2) != 0);
         rsp_stalls = ($urandom_range(0, 2) != 0);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(0, 1)) begin
               w_beg = cfg.count_window[63:32];
               w_end = cfg.count_window[31:0];
            end else begin
               w_beg = cfg.dir_window[63:32];
               w_end = cfg.dir_window[31:0];
            end
            case ($urandom_range(0, 9))
               0, 1, 2:    stamp = prev_stamp + $urandom_range(0, 40);
               3, 4, 5, 6: stamp = w_beg + $urandom_range(0, w_end - w_beg);
               7:          stamp = w_end + $urandom_range(0, 4) - 32'd2;
               8:          stamp = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
               default:    stamp = $urandom;
            endcase
            send_stamp(stamp);
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_COUNT_WINDOW;
      csr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_power_up();
      test_count_ramp();
      test_wrap_quotient();
      test_reversed_windows();
      test_full_range();
      test_random_phases();
      drain(SETTLE_CYCLES);

      $display("Sent %0d frame stamps, checked %0d result words over %0d register loads.",
               words_sent, words_seen, settings_loaded);
      $display("Covered empty, short, long, reversed and full-range windows with gaps and stalls.");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
